// ===== rtl/rde_pkg.sv =====
`default_nettype none

package rde_pkg;

  // Default sizing
  localparam int unsigned VALUE_WIDTH_DEF = 64;
  localparam int unsigned MAX_DIGITS_DEF  = 22;

  // Number of quotient bits retired per cycle by the divide step
  localparam int unsigned BITS_PER_STEP = 4;

  // Field widths
  localparam int unsigned IN_WIDTH    = 64;
  localparam int unsigned RADIX_WIDTH = 5;
  localparam int unsigned CHAR_WIDTH  = 8;
  localparam int unsigned COUNT_WIDTH = 5;
  localparam int unsigned DIGIT_WIDTH = 4;

  // Radix limits
  localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = 5'd8;
  localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = 5'd16;

  // ASCII codes
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_X       = 8'h78;
  localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_WIDTH-1:0] CHAR_UPPER_A = 8'h41;

  // Prefix characters still to send
  localparam logic [1:0] PFX_NONE = 2'd0;
  localparam logic [1:0] PFX_X    = 2'd1;
  localparam logic [1:0] PFX_ZERO = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_EMIT   = 3'b100
  } rde_state_e;

  // Map one digit to its ASCII character
  function automatic logic [CHAR_WIDTH-1:0] digit_char(
    input logic [DIGIT_WIDTH-1:0] digit,
    input logic                   upper
  );
    logic [CHAR_WIDTH-1:0] base;
    base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    if (digit < 4'd10) begin
      digit_char = CHAR_ZERO + CHAR_WIDTH'(digit);
    end else begin
      digit_char = base + CHAR_WIDTH'(digit - 4'd10);
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/radix_digit_emitter.sv =====
`default_nettype none

// Channel | direction | handshake                 | payload
// --------+-----------+---------------------------+--------------------------------------
// in      | receive   | in_valid_i / in_stall_o   | value_i, radix_i, upper_case_i,
//         |           |                           | with_prefix_i
// out     | send      | out_valid_o / out_stall_i | character_o, last_o, printed_count_o
//
// One word in gives one output word per character. Each digit is the
// remainder of dividing the running quotient by the radix, BITS_PER_STEP
// quotient bits per divide step; output stalls hold the emission. Hold the
// input stalled from accept until the last character enters the output
// register. An asynchronous low rst_ni returns the sequencer to idle and
// empties the output register; the digit stack is not cleared.

module radix_digit_emitter #(
  parameter int unsigned VALUE_WIDTH = rde_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned MAX_DIGITS  = rde_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // input words
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [rde_pkg::IN_WIDTH-1:0]        value_i,
  input  wire logic [rde_pkg::RADIX_WIDTH-1:0]     radix_i,
  input  wire logic                                upper_case_i,
  input  wire logic                                with_prefix_i,
  // output words
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic [rde_pkg::CHAR_WIDTH-1:0]           character_o,
  output logic                                     last_o,
  output logic [rde_pkg::COUNT_WIDTH-1:0]          printed_count_o
);

  localparam int unsigned B      = rde_pkg::BITS_PER_STEP;
  localparam int unsigned STEPS  = (VALUE_WIDTH + B - 1) / B;
  localparam int unsigned QW     = STEPS * B;
  localparam int unsigned STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IDX_W  = $clog2(MAX_DIGITS);
  localparam int unsigned RW     = rde_pkg::RADIX_WIDTH;
  localparam int unsigned DW     = rde_pkg::DIGIT_WIDTH;
  localparam int unsigned CW     = rde_pkg::CHAR_WIDTH;
  localparam int unsigned PW     = rde_pkg::COUNT_WIDTH;

  rde_pkg::rde_state_e state_q, state_d;

  // Working registers of the divider
  logic [QW-1:0]     quo_q, quo_d;
  logic [RW-1:0]     rem_q, rem_d;
  logic [RW-1:0]     radix_q, radix_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              upper_q, upper_d;
  logic [1:0]        pfx_q, pfx_d;
  logic [PW-1:0]     total_q, total_d;

  // Digit stack, least significant digit at the bottom
  logic [DW-1:0]     stack_q [MAX_DIGITS];

  // Output register
  logic              ovalid_q, ovalid_d;
  logic [CW-1:0]     ochar_q, ochar_d;
  logic              olast_q, olast_d;
  logic [PW-1:0]     ocount_q, ocount_d;

  logic              in_take;
  logic              out_free;
  logic [RW-1:0]     radix_sat;
  logic [QW-1:0]     step_quo;
  logic [RW-1:0]     step_rem;
  logic              digit_done;
  logic              push;
  logic [CNT_W-1:0]  read_pos;
  logic [DW-1:0]     read_digit;

  assign in_stall_o = (state_q != rde_pkg::ST_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !ovalid_q || !out_stall_i;

  // Clamp the radix into 8..16
  always_comb begin
    if (radix_i < rde_pkg::RADIX_MIN) begin
      radix_sat = rde_pkg::RADIX_MIN;
    end else if (radix_i > rde_pkg::RADIX_MAX) begin
      radix_sat = rde_pkg::RADIX_MAX;
    end else begin
      radix_sat = radix_i;
    end
  end

  // Shared divide step: B restoring shift/subtract steps on a 5-bit
  // partial remainder, MSB of the quotient register shifts in each time.
  always_comb begin
    logic [RW-1:0] r_v;
    logic [QW-1:0] q_v;
    r_v = rem_q;
    q_v = quo_q;
    for (int b = 0; b < B; b++) begin
      r_v = {r_v[RW-2:0], q_v[QW-1]};
      q_v = {q_v[QW-2:0], 1'b0};
      if (r_v >= radix_q) begin
        r_v    = r_v - radix_q;
        q_v[0] = 1'b1;
      end
    end
    step_quo = q_v;
    step_rem = r_v;
  end

  assign digit_done = (state_q == rde_pkg::ST_DIVIDE) && (step_q == STEP_W'(STEPS - 1));
  assign push       = digit_done && (count_q < CNT_W'(MAX_DIGITS));

  // Stack read, top of the remaining digits
  assign read_pos   = count_q - CNT_W'(1);
  assign read_digit = stack_q[read_pos[IDX_W-1:0]];

  always_comb begin
    state_d  = state_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    radix_d  = radix_q;
    step_d   = step_q;
    count_d  = count_q;
    upper_d  = upper_q;
    pfx_d    = pfx_q;
    total_d  = total_q;
    ovalid_d = ovalid_q && out_stall_i;
    ochar_d  = ochar_q;
    olast_d  = olast_q;
    ocount_d = ocount_q;

    case (state_q)
      rde_pkg::ST_IDLE: begin
        if (in_take) begin
          quo_d   = QW'(value_i[VALUE_WIDTH-1:0]);
          rem_d   = '0;
          radix_d = radix_sat;
          step_d  = '0;
          count_d = '0;
          upper_d = upper_case_i;
          pfx_d   = with_prefix_i ? rde_pkg::PFX_ZERO : rde_pkg::PFX_NONE;
          state_d = rde_pkg::ST_DIVIDE;
        end
      end

      rde_pkg::ST_DIVIDE: begin
        quo_d  = step_quo;
        rem_d  = step_rem;
        step_d = step_q + STEP_W'(1);
        if (digit_done) begin
          // Restart the divider on the quotient; keep the low digits only
          rem_d  = '0;
          step_d = '0;
          if (push) begin
            count_d = count_q + CNT_W'(1);
          end
          if (step_quo == '0) begin
            total_d = PW'(push ? count_q + CNT_W'(1) : count_q)
                    + ((pfx_q == rde_pkg::PFX_ZERO) ? PW'(2) : PW'(0));
            state_d = rde_pkg::ST_EMIT;
          end
        end
      end

      rde_pkg::ST_EMIT: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          olast_d  = 1'b0;
          ocount_d = '0;
          case (pfx_q)
            rde_pkg::PFX_ZERO: begin
              ochar_d = rde_pkg::CHAR_ZERO;
              pfx_d   = rde_pkg::PFX_X;
            end
            rde_pkg::PFX_X: begin
              ochar_d = rde_pkg::CHAR_X;
              pfx_d   = rde_pkg::PFX_NONE;
            end
            default: begin
              ochar_d = rde_pkg::digit_char(read_digit, upper_q);
              count_d = read_pos;
              if (count_q == CNT_W'(1)) begin
                olast_d  = 1'b1;
                ocount_d = total_q;
                state_d  = rde_pkg::ST_IDLE;
              end
            end
          endcase
        end
      end

      default: begin
        state_d = rde_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= rde_pkg::ST_IDLE;
      step_q   <= '0;
      count_q  <= '0;
      pfx_q    <= rde_pkg::PFX_NONE;
      ovalid_q <= 1'b0;
      quo_q    <= '0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      count_q  <= count_d;
      pfx_q    <= pfx_d;
      ovalid_q <= ovalid_d;
      quo_q    <= quo_d;
    end
  end

  // Payload, no reset
  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    radix_q  <= radix_d;
    upper_q  <= upper_d;
    total_q  <= total_d;
    ochar_q  <= ochar_d;
    olast_q  <= olast_d;
    ocount_q <= ocount_d;
    if (push) begin
      stack_q[count_q[IDX_W-1:0]] <= step_rem[DW-1:0];
    end
  end

  assign out_valid_o     = ovalid_q;
  assign character_o     = ochar_q;
  assign last_o          = olast_q;
  assign printed_count_o = ocount_q;

endmodule

`default_nettype wire
